FILE: src/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared types and constants of the piecewise colormap lookup block.
// ----------------------------------------------------------------------------
package pcl_pkg;

  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BP_COUNT = 2'd0,
    CFG_INTERP   = 2'd1,
    CFG_ALPHA    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_MAP  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PROBE,
    BK_WAIT,
    BK_FETCH,
    BK_DIV,
    BK_BLEND,
    BK_OUT
  } bk_state_t;

  // Blend unit control between the back end and the channel blender.
  typedef struct packed {
    logic       start;
    logic       interp;
    logic       alpha_on;
  } blend_ctl_t;

endpackage

FILE: src/piecewise_colormap_lookup.sv
// ----------------------------------------------------------------------------
// piecewise_colormap_lookup
// Scalar to RGBA lookup through a loaded breakpoint/color table.
// ----------------------------------------------------------------------------
// A load is written to the tables by the back end; a map result follows a
// binary search of up to ceil(log2(N-1)) steps and a fetch of the entry.
// Interpolating adds a fetch of the upper entry and a per-channel blend,
// plus a serial restoring divide when the sample lies inside its segment.
// Throughput: one map item at a time; the input queue takes two items ahead.
// Reset: synchronous active-low rst_n resets control and config registers;
// the tables are undefined until loaded.
module piecewise_colormap_lookup #(
  parameter int MAX_ENTRIES = 64,
  parameter int VALUE_BITS  = 32,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [6:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [5:0]            in_entry_index,
  input  logic [VALUE_BITS-1:0] in_sample_value,
  input  logic [7:0]            in_load_red,
  input  logic [7:0]            in_load_green,
  input  logic [7:0]            in_load_blue,
  input  logic [7:0]            in_load_alpha,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  output logic [5:0]            out_segment_found
);

  logic [6:0] bp_count_r;
  logic       interp_r, alpha_r;
  logic       q_valid, q_pop, q_kind;
  logic [5:0] q_index;
  logic [VALUE_BITS-1:0] q_value;
  logic [31:0] q_color, color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_count_r <= 7'd2;
      interp_r   <= 1'b0;
      alpha_r    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcl_pkg::CFG_BP_COUNT: bp_count_r <= cfg_data;
        pcl_pkg::CFG_INTERP:   interp_r   <= cfg_data[0];
        pcl_pkg::CFG_ALPHA:    alpha_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pcl_front #(.IW(6), .VB(VALUE_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_kind, .in_index(in_entry_index), .in_value(in_sample_value),
    .in_color({in_load_alpha, in_load_blue, in_load_green, in_load_red}),
    .q_valid, .q_pop, .q_kind, .q_index, .q_value, .q_color
  );

  pcl_back #(.MAX_ENTRIES(MAX_ENTRIES), .VALUE_BITS(VALUE_BITS),
             .WEIGHT_BITS(WEIGHT_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_kind, .q_index, .q_value, .q_color,
    .bp_count(bp_count_r), .interp(interp_r), .alpha_on(alpha_r),
    .out_valid, .out_ready, .out_color(color), .out_seg(out_segment_found)
  );

  assign {out_alpha, out_blue, out_green, out_red} = color;

endmodule

FILE: src/pcl_ram.sv
// ----------------------------------------------------------------------------
// pcl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/pcl_front.sv
// ----------------------------------------------------------------------------
// pcl_front
// Accepts input items and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pcl_front #(
  parameter int IW = 6,
  parameter int VB = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_kind,
  input  logic [IW-1:0] in_index,
  input  logic [VB-1:0] in_value,
  input  logic [31:0]   in_color,
  output logic          q_valid,
  input  logic          q_pop,
  output logic          q_kind,
  output logic [IW-1:0] q_index,
  output logic [VB-1:0] q_value,
  output logic [31:0]   q_color
);

  localparam int EW = 1 + IW + VB + 32;

  logic [EW-1:0] slot_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign {q_kind, q_index, q_value, q_color} = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= {in_kind, in_index, in_value, in_color};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> cnt_r == 2'd2)
    else $error("full queue lost an item");

endmodule

FILE: src/pcl_back.sv
// ----------------------------------------------------------------------------
// pcl_back
// Executes queued items: table writes, binary search over the breakpoint
// RAM, serial restoring divide for the weight, and a per-channel blend.
// ----------------------------------------------------------------------------
module pcl_back #(
  parameter int MAX_ENTRIES = 64,
  parameter int VALUE_BITS  = 32,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  logic                           q_kind,
  input  logic [5:0]                     q_index,
  input  logic [VALUE_BITS-1:0]          q_value,
  input  logic [31:0]                    q_color,
  input  logic [6:0]                     bp_count,
  input  logic                           interp,
  input  logic                           alpha_on,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    out_color,
  output logic [5:0]                     out_seg
);

  localparam int AW  = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
  localparam int DW  = VALUE_BITS + 1;
  localparam int NW  = DW + WEIGHT_BITS;
  localparam int WCW = $clog2(NW + 1);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);

  pcl_pkg::bk_state_t state_r, state_nxt;

  logic [AW-1:0]  lo_r, hi_r, k_r, j_r;
  logic [VALUE_BITS-1:0] val_r, bpj_r;
  logic [31:0]    cj_r;
  logic [NW-1:0]  rem_r;
  logic [NW-1:0]  quo_r;
  logic [DW-1:0]  den_r;
  logic [WCW-1:0] bit_r;
  logic           fetch_hi_r;
  logic [WEIGHT_BITS:0] a_r;
  logic [31:0]    res_r;
  logic [5:0]     seg_r;
  logic [1:0]     ch_r;

  logic           is_load, we;
  logic [AW-1:0]  raddr;
  logic [VALUE_BITS-1:0] bp_rd;
  logic [31:0]    col_rd;
  logic [CW-1:0]  n_cl;
  logic [AW-1:0]  probe;

  always_comb begin
    if (bp_count < 7'd2) n_cl = CW'(2);
    else if (32'(bp_count) > MAX_ENTRIES) n_cl = CW'(MAX_ENTRIES);
    else n_cl = CW'(bp_count);
  end

  assign is_load = q_valid && (state_r == pcl_pkg::BK_IDLE) && (q_kind == pcl_pkg::KIND_LOAD);
  assign we      = is_load && (32'(q_index) < MAX_ENTRIES);
  assign probe   = lo_r + AW'((hi_r - lo_r + AW'(1)) >> 1);

  // Outside the search the read address stays on the upper entry once it is
  // fetched, so the blend sees that entry's color for all four channels.
  always_comb begin
    unique case (state_r)
      pcl_pkg::BK_PROBE: raddr = probe;
      default:           raddr = fetch_hi_r ? AW'(j_r + AW'(1)) : j_r;
    endcase
  end

  pcl_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ENTRIES)) u_bp (
    .clk(clk), .we(we), .waddr(q_index[AW-1:0]), .wdata(q_value),
    .raddr(raddr), .rdata(bp_rd)
  );

  pcl_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_col (
    .clk(clk), .we(we), .waddr(q_index[AW-1:0]), .wdata(q_color),
    .raddr(raddr), .rdata(col_rd)
  );

  // Blend of one channel per cycle: a*cj + (1-a)*ck, rounded.
  logic [7:0] cj_ch, ck_ch;
  logic [WEIGHT_BITS+9:0] acc;
  logic [WEIGHT_BITS+9:0] acc_sh;
  logic [7:0] blend_ch;
  assign cj_ch = cj_r[8*ch_r +: 8];
  assign ck_ch = col_rd[8*ch_r +: 8];
  assign acc = (WEIGHT_BITS+10)'(a_r) * (WEIGHT_BITS+10)'(cj_ch)
             + (WEIGHT_BITS+10)'((WEIGHT_BITS+1)'(1 << WEIGHT_BITS) - a_r)
               * (WEIGHT_BITS+10)'(ck_ch)
             + (WEIGHT_BITS+10)'(1 << (WEIGHT_BITS-1));
  assign acc_sh = acc >> WEIGHT_BITS;
  assign blend_ch = (acc_sh > 255) ? 8'hFF : acc_sh[7:0];

  logic signed [DW-1:0] sv, lov, hiv;
  logic [NW-1:0] trial;
  assign sv    = {val_r[VALUE_BITS-1], val_r};
  assign lov   = {bpj_r[VALUE_BITS-1], bpj_r};
  assign hiv   = {bp_rd[VALUE_BITS-1], bp_rd};
  assign trial = {rem_r[NW-2:0], quo_r[NW-1]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcl_pkg::BK_IDLE:
        if (q_valid && q_kind == pcl_pkg::KIND_MAP) state_nxt = pcl_pkg::BK_PROBE;
      pcl_pkg::BK_PROBE:
        if (lo_r >= hi_r) state_nxt = pcl_pkg::BK_WAIT;
      pcl_pkg::BK_WAIT:  state_nxt = pcl_pkg::BK_FETCH;
      pcl_pkg::BK_FETCH:
        if (!fetch_hi_r) begin
          state_nxt = interp ? pcl_pkg::BK_WAIT : pcl_pkg::BK_OUT;
        end else if (sv <= lov || sv >= hiv) begin
          state_nxt = pcl_pkg::BK_BLEND;
        end else begin
          state_nxt = pcl_pkg::BK_DIV;
        end
      pcl_pkg::BK_DIV:
        if (bit_r == WCW'(0)) state_nxt = pcl_pkg::BK_BLEND;
      pcl_pkg::BK_BLEND:
        if (ch_r == 2'd3) state_nxt = pcl_pkg::BK_OUT;
      pcl_pkg::BK_OUT:
        if (out_ready) state_nxt = pcl_pkg::BK_IDLE;
      default: state_nxt = pcl_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = q_valid && (state_r == pcl_pkg::BK_IDLE);
    out_valid = (state_r == pcl_pkg::BK_OUT);
    out_color = res_r;
    out_seg   = seg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pcl_pkg::BK_IDLE;
    else        state_r <= state_nxt;
  end

  // Probe reads are issued in PROBE and the compare lands in the following
  // cycle; k_r holds the probed index and probe_pend_r marks the pending probe.
  logic probe_pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_pend_r <= 1'b0;
    end else begin
      unique case (state_r)
        pcl_pkg::BK_IDLE: begin
          probe_pend_r <= 1'b0;
          if (q_valid && q_kind == pcl_pkg::KIND_MAP) begin
            val_r      <= q_value;
            lo_r       <= '0;
            hi_r       <= AW'(n_cl - CW'(2));
            fetch_hi_r <= 1'b0;
            ch_r       <= 2'd0;
          end
        end
        pcl_pkg::BK_PROBE: begin
          if (probe_pend_r) begin
            probe_pend_r <= 1'b0;
            if ($signed(val_r) >= $signed(bp_rd)) lo_r <= k_r;
            else hi_r <= AW'(k_r - AW'(1));
          end else if (lo_r < hi_r) begin
            probe_pend_r <= 1'b1;
            k_r <= probe;
          end
          j_r <= hi_r;
        end
        pcl_pkg::BK_FETCH: begin
          if (!fetch_hi_r) begin
            cj_r       <= col_rd;
            bpj_r      <= bp_rd;
            fetch_hi_r <= 1'b1;
            seg_r      <= 6'(j_r);
            res_r      <= {alpha_on ? col_rd[31:24] : 8'hFF, col_rd[23:0]};
          end else begin
            if (sv <= lov) a_r <= (WEIGHT_BITS+1)'(1 << WEIGHT_BITS);
            else if (sv >= hiv) a_r <= '0;
            rem_r <= '0;
            quo_r <= NW'(hiv - sv) << WEIGHT_BITS;
            den_r <= DW'(hiv - lov);
            bit_r <= WCW'(NW);
          end
        end
        pcl_pkg::BK_DIV: begin
          if (bit_r != WCW'(0)) begin
            bit_r <= bit_r - WCW'(1);
            if (trial >= NW'(den_r)) begin
              rem_r <= trial - NW'(den_r);
              quo_r <= {quo_r[NW-2:0], 1'b1};
            end else begin
              rem_r <= trial;
              quo_r <= {quo_r[NW-2:0], 1'b0};
            end
          end else begin
            a_r <= (quo_r > NW'(1 << WEIGHT_BITS)) ?
                   (WEIGHT_BITS+1)'(1 << WEIGHT_BITS) : quo_r[WEIGHT_BITS:0];
          end
        end
        pcl_pkg::BK_BLEND: begin
          ch_r <= ch_r + 2'd1;
          res_r[8*ch_r +: 8] <= (ch_r == 2'd3 && !alpha_on) ? 8'hFF : blend_ch;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_color))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !out_valid)
    else $error("item taken while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_seg) <= MAX_ENTRIES - 2)
    else $error("segment out of range");

endmodule

FILE: tb/piecewise_colormap_lookup_tb.sv
// ----------------------------------------------------------------------------
// piecewise_colormap_lookup_tb
// Self-checking bench for the colormap lookup. A directed table runs first.
// Random phases follow: each loads a table of breakpoints and colors, then
// mixes map items with loads. Results are checked against a predictor or
// the directed row's value. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module piecewise_colormap_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TARGET_ITEMS = 1050;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [5:0] seg;
  } color_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_op_t;

  typedef struct {
    row_op_t         op;
    pcl_pkg::kind_t  kind;
    logic [5:0]      idx;
    logic [31:0]     val;
    logic [7:0]      r, g, b, a;
    bit              typed;
    color_t          want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [5:0] in_entry_index = '0;
  logic [31:0] in_sample_value = '0;
  logic [7:0] in_load_red = '0, in_load_green = '0, in_load_blue = '0, in_load_alpha = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  logic [5:0] out_segment_found;

  piecewise_colormap_lookup dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's tables and registers.
  logic signed [31:0] bp_mem [64];
  logic [7:0] col_mem [64][4];
  logic [6:0] count_reg = 7'd2;
  bit interp_on = 1'b0;
  bit alpha_on = 1'b0;

  color_t pending_colors[$];
  int fail_count = 0;
  int item_count = 0;
  bit steady = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;

  function automatic int used_entries();
    int n;
    n = count_reg;
    if (n < 2) n = 2;
    if (n > 64) n = 64;
    return n;
  endfunction

  function automatic color_t lookup_color(logic signed [31:0] s);
    color_t c;
    int lo_i, hi_i, mid, ch;
    longint lo, hi, w, acc;
    logic [7:0] res [4];
    lo_i = 0;
    hi_i = used_entries() - 2;
    while (lo_i < hi_i) begin
      mid = lo_i + (hi_i - lo_i + 1) / 2;
      if (s >= bp_mem[mid]) lo_i = mid;
      else hi_i = mid - 1;
    end
    if (!interp_on) begin
      for (ch = 0; ch < 4; ch++) res[ch] = col_mem[hi_i][ch];
    end else begin
      lo = bp_mem[hi_i];
      hi = bp_mem[hi_i + 1];
      if (longint'(s) <= lo) w = 65536;
      else if (longint'(s) >= hi) w = 0;
      else begin
        w = ((hi - longint'(s)) << 16) / (hi - lo);
        if (w > 65536) w = 65536;
      end
      for (ch = 0; ch < 4; ch++) begin
        acc = (w * col_mem[hi_i][ch] + (65536 - w) * col_mem[hi_i + 1][ch] + 32768) >> 16;
        res[ch] = (acc > 255) ? 8'd255 : acc[7:0];
      end
    end
    if (!alpha_on) res[3] = 8'd255;
    c = '{res[0], res[1], res[2], res[3], hi_i[5:0]};
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, occasional long ones, and requested hold-offs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_cnt <= 400;
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 2) begin
      hold_cnt <= $urandom_range(15, 50);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    color_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_colors.size() == 0) begin
        $error("result with no expected item: seg %0d", out_segment_found);
        fail_count++;
      end else begin
        e = pending_colors.pop_front();
        if (out_red !== e.red) begin
          $error("out_red expected %0d got %0d", e.red, out_red);
          fail_count++;
        end
        if (out_green !== e.green) begin
          $error("out_green expected %0d got %0d", e.green, out_green);
          fail_count++;
        end
        if (out_blue !== e.blue) begin
          $error("out_blue expected %0d got %0d", e.blue, out_blue);
          fail_count++;
        end
        if (out_alpha !== e.alpha) begin
          $error("out_alpha expected %0d got %0d", e.alpha, out_alpha);
          fail_count++;
        end
        if (out_segment_found !== e.seg) begin
          $error("out_segment_found expected %0d got %0d", e.seg, out_segment_found);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(pcl_pkg::kind_t k, logic [5:0] idx, logic [31:0] val,
                           logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [7:0] a, bit typed, color_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_entry_index <= idx;
    in_sample_value <= val;
    in_load_red <= r;
    in_load_green <= g;
    in_load_blue <= b;
    in_load_alpha <= a;
    do @(posedge clk); while (!in_ready);
    item_count++;
    if (k == pcl_pkg::KIND_LOAD) begin
      bp_mem[idx] = val;
      col_mem[idx] = '{r, g, b, a};
    end else begin
      pending_colors.push_back(typed ? want : lookup_color(val));
    end
  endtask

  // Lowers in_valid, then waits out every result and any load still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_colors.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(pcl_pkg::cfg_reg_t reg_idx, logic [6:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= reg_idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (reg_idx)
      pcl_pkg::CFG_BP_COUNT: count_reg = data;
      pcl_pkg::CFG_INTERP:   interp_on = data[0];
      pcl_pkg::CFG_ALPHA:    alpha_on = data[0];
      default: ;
    endcase
  endtask

  task automatic random_sample(output logic [31:0] s);
    int n, e, r;
    longint lo, hi, span;
    n = used_entries();
    r = $urandom_range(0, 99);
    if (r < 30) begin
      e = $urandom_range(0, n - 1);
      s = bp_mem[e] + $urandom_range(0, 2) - 1;
    end else if (r < 85) begin
      lo = bp_mem[0];
      hi = bp_mem[n - 1];
      if (hi <= lo) hi = lo + 1;
      span = hi - lo + 4096;
      s = 32'(lo - 2048 + longint'({$urandom, $urandom} % span));
    end else begin
      s = $urandom;
    end
  endtask

  initial begin
    stim_row_t rows [11];
    color_t none;
    int phase, n, e, maps, m, count_val;
    longint base, step, v;
    logic [31:0] s;
    none = '0;
    rows = '{
      '{ROW_ITEM, pcl_pkg::KIND_LOAD, 6'd0, 32'h8000_0000, 8'd0, 8'd0, 8'd0, 8'd0, 0, none},
      '{ROW_ITEM, pcl_pkg::KIND_LOAD, 6'd1, 32'h7fff_ffff, 8'd255, 8'd255, 8'd255, 8'd255,
        0, none},
      '{ROW_ITEM, pcl_pkg::KIND_MAP, 6'd0, 32'h8000_0000, 8'd0, 8'd0, 8'd0, 8'd0, 1,
        '{8'd0, 8'd0, 8'd0, 8'd255, 6'd0}},
      '{ROW_ITEM, pcl_pkg::KIND_MAP, 6'd63, 32'h7fff_ffff, 8'd255, 8'd255, 8'd255, 8'd255, 1,
        '{8'd0, 8'd0, 8'd0, 8'd255, 6'd0}},
      '{ROW_CFG, pcl_pkg::KIND_LOAD, 6'(pcl_pkg::CFG_ALPHA), 32'd1, 8'd0, 8'd0, 8'd0, 8'd0,
        0, none},
      '{ROW_CFG, pcl_pkg::KIND_LOAD, 6'(pcl_pkg::CFG_INTERP), 32'd1, 8'd0, 8'd0, 8'd0, 8'd0,
        0, none},
      '{ROW_ITEM, pcl_pkg::KIND_MAP, 6'd0, 32'h8000_0000, 8'd0, 8'd0, 8'd0, 8'd0, 1,
        '{8'd0, 8'd0, 8'd0, 8'd0, 6'd0}},
      '{ROW_ITEM, pcl_pkg::KIND_MAP, 6'd0, 32'h7fff_ffff, 8'd0, 8'd0, 8'd0, 8'd0, 1,
        '{8'd255, 8'd255, 8'd255, 8'd255, 6'd0}},
      '{ROW_ITEM, pcl_pkg::KIND_MAP, 6'd0, 32'h0000_0000, 8'd0, 8'd0, 8'd0, 8'd0, 0, none},
      '{ROW_ITEM, pcl_pkg::KIND_MAP, 6'd0, 32'hffff_ffff, 8'd0, 8'd0, 8'd0, 8'd0, 0, none},
      '{ROW_ITEM, pcl_pkg::KIND_LOAD, 6'd63, 32'h1234_5678, 8'ha5, 8'h5a, 8'hff, 8'h00,
        0, none}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].op == ROW_CFG) begin
        drain();
        write_cfg(pcl_pkg::cfg_reg_t'(rows[i].idx[1:0]), rows[i].val[6:0]);
      end else begin
        send_item(rows[i].kind, rows[i].idx, rows[i].val, rows[i].r, rows[i].g,
                  rows[i].b, rows[i].a, rows[i].typed, rows[i].want);
      end
    end

    phase = 0;
    while (item_count < TARGET_ITEMS) begin
      drain();
      case (phase % 8)
        0: count_val = 64;
        1: count_val = 0;
        2: count_val = 127;
        3: count_val = 1;
        4: count_val = 65;
        5: count_val = 2;
        default: count_val = $urandom_range(2, 64);
      endcase
      write_cfg(pcl_pkg::CFG_BP_COUNT, 7'(count_val));
      write_cfg(pcl_pkg::CFG_INTERP, 7'($urandom_range(0, 1)));
      write_cfg(pcl_pkg::CFG_ALPHA, 7'($urandom_range(0, 1)));
      steady = (phase % 5 == 4);
      if (phase == 3) hold_requests++;
      n = used_entries();

      // Ascending table, occasionally left unordered or with extreme ends.
      step = longint'($urandom_range(1, 32'h7fff_ffff)) % (64'h1_0000_0000 / n) + 1;
      base = -64'sd2147483648 + longint'($urandom) % (64'h1_0000_0000 - step * (n - 1));
      for (e = 0; e < n; e++) begin
        v = base + step * e;
        if ($urandom_range(0, 9) == 0) v = $signed(32'($urandom));
        if (phase % 6 == 1 && e == 0) v = -64'sd2147483648;
        if (phase % 6 == 1 && e == n - 1) v = 64'sd2147483647;
        send_item(pcl_pkg::KIND_LOAD, 6'(e), 32'(v), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 0, none);
      end

      maps = $urandom_range(20, 45);
      for (m = 0; m < maps; m++) begin
        if (phase == 5 && m == maps / 2 && pending_colors.size() != 0) begin
          in_valid <= 1'b0;
          wait (pending_colors.size() == 0);
        end
        if ($urandom_range(0, 9) == 0) begin
          // A rewrite of any entry keeps all used entries defined.
          send_item(pcl_pkg::KIND_LOAD, 6'($urandom_range(0, 63)), $urandom, 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom), 0, none);
        end else begin
          random_sample(s);
          send_item(pcl_pkg::KIND_MAP, 6'($urandom), s, 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 0, none);
        end
      end
      phase++;
    end

    drain();
    if (pending_colors.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
